@@ hdl/nat_pkg.sv @@
`default_nettype none
package nat_pkg;

   localparam int NODE_SLOTS     = 32;
   localparam int INCIDENT_SLOTS = 32;
   localparam int NODE_IDX_W     = $clog2(NODE_SLOTS);
   localparam int INC_IDX_W      = $clog2(INCIDENT_SLOTS);
   localparam int NODE_CNT_W     = $clog2(NODE_SLOTS + 1);
   localparam int INC_CNT_W      = $clog2(INCIDENT_SLOTS + 1);

   typedef logic [NODE_IDX_W-1:0] nat_nidx_type;
   typedef logic [INC_IDX_W-1:0]  nat_iidx_type;
   typedef logic [NODE_CNT_W-1:0] nat_ncnt_type;
   typedef logic [INC_CNT_W-1:0]  nat_icnt_type;

   // command codes
   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_STATUS = 1'b1;

   // incident states
   localparam logic [2:0] INC_ACTIVE   = 3'd0;
   localparam logic [2:0] INC_RESOLVED = 3'd1;

   // node flag words: bit 0 sos active, bit 1 calm (no sos)
   localparam logic [1:0] FLAGS_SOS  = 2'b01;
   localparam logic [1:0] FLAGS_CALM = 2'b10;

   // incident actions
   localparam logic [1:0] ACT_NONE         = 2'd0;
   localparam logic [1:0] ACT_REFRESH      = 2'd1;
   localparam logic [1:0] ACT_CREATE_FREE  = 2'd2;
   localparam logic [1:0] ACT_CREATE_EVICT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NSCAN,
      ST_NWRITE,
      ST_ISCAN,
      ST_IWRITE,
      ST_RESP
   } nat_state_type;

   typedef struct packed {
      logic        command;
      logic [15:0] node_id;
      logic [31:0] sequence_req;
      logic [7:0]  hop_count;
      logic [7:0]  signal_strength;
      logic        sos_flag;
      logic [2:0]  status_code;
      logic [31:0] now_ms;
   } nat_req_type;

   // token walking the node chain
   typedef struct packed {
      logic         vld;
      logic         mhit;
      nat_nidx_type mslot;
      logic         mact;
      logic         fhit;
      nat_nidx_type fslot;
      logic         ohit;
      logic [31:0]  otime;
      nat_nidx_type oslot;
      logic         oact;
      nat_ncnt_type vcnt;
      nat_ncnt_type scnt;
   } nat_node_tok_type;

   // token walking the incident chain
   typedef struct packed {
      logic         vld;
      logic         upd_mode;
      logic         mhit;
      nat_iidx_type mslot;
      logic         fhit;
      nat_iidx_type fslot;
      logic         ohit;
      logic [31:0]  otime;
      nat_iidx_type oslot;
      nat_icnt_type ucnt;
   } nat_inc_tok_type;

   typedef struct packed {
      logic         en;
      nat_nidx_type slot;
   } nat_nwr_type;

   typedef struct packed {
      logic         en;
      logic         create;
      nat_iidx_type slot;
      logic [15:0]  link;
   } nat_iwr_type;

endpackage
`default_nettype wire

@@ hdl/nat_node_cell.sv @@
`default_nettype none
module nat_node_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  nat_pkg::nat_nidx_type     my_idx,
   input  nat_pkg::nat_req_type      req,
   input  nat_pkg::nat_nwr_type      wr,
   input  nat_pkg::nat_node_tok_type tok_in,
   output nat_pkg::nat_node_tok_type tok_out
);

   logic                      valid_ff;
   logic [15:0]               ident_ff;
   logic [31:0]               seq_ff;
   logic [7:0]                hops_ff;
   logic [7:0]                sig_ff;
   logic [1:0]                flags_ff;
   logic [31:0]               first_ff;
   logic [31:0]               last_ff;
   nat_pkg::nat_node_tok_type tok_ff;
   nat_pkg::nat_node_tok_type tok_in_c;
   logic                      act;
   logic                      wr_hit;

   assign act    = valid_ff && (flags_ff == nat_pkg::FLAGS_SOS);
   assign wr_hit = wr.en && (wr.slot == my_idx);

   // fold this entry into the passing token
   always_comb begin
      tok_in_c = tok_in;
      if (valid_ff && (ident_ff == req.node_id) && !tok_in.mhit) begin
         tok_in_c.mhit  = 1'b1;
         tok_in_c.mslot = my_idx;
         tok_in_c.mact  = act;
      end
      if (!valid_ff && !tok_in.fhit) begin
         tok_in_c.fhit  = 1'b1;
         tok_in_c.fslot = my_idx;
      end
      if (!tok_in.ohit || (last_ff < tok_in.otime)) begin
         tok_in_c.ohit  = 1'b1;
         tok_in_c.otime = last_ff;
         tok_in_c.oslot = my_idx;
         tok_in_c.oact  = act;
      end
      if (valid_ff) begin
         tok_in_c.vcnt = tok_in.vcnt + nat_pkg::nat_ncnt_type'(1);
      end
      if (act) begin
         tok_in_c.scnt = tok_in.scnt + nat_pkg::nat_ncnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_c;
         if (wr_hit) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         if (!valid_ff) begin
            first_ff <= req.now_ms;
         end
         ident_ff <= req.node_id;
         seq_ff   <= req.sequence_req;
         hops_ff  <= req.hop_count;
         sig_ff   <= req.signal_strength;
         flags_ff <= req.sos_flag ? nat_pkg::FLAGS_SOS : nat_pkg::FLAGS_CALM;
         last_ff  <= req.now_ms;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

@@ hdl/nat_inc_cell.sv @@
`default_nettype none
module nat_inc_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  nat_pkg::nat_iidx_type    my_idx,
   input  nat_pkg::nat_req_type     req,
   input  nat_pkg::nat_iwr_type     wr,
   input  nat_pkg::nat_inc_tok_type tok_in,
   output nat_pkg::nat_inc_tok_type tok_out
);

   logic                     valid_ff;
   logic [15:0]              node_ff;
   logic [31:0]              seq_ff;
   logic [15:0]              link_ff;
   logic [2:0]               state_ff;
   logic [31:0]              created_ff;
   logic [31:0]              updated_ff;
   nat_pkg::nat_inc_tok_type tok_ff;
   nat_pkg::nat_inc_tok_type tok_in_c;
   logic                     wr_hit;
   logic                     stat_hit;

   assign wr_hit   = wr.en && (wr.slot == my_idx);
   assign stat_hit = tok_in.vld && tok_in.upd_mode && valid_ff &&
                     (node_ff == req.node_id) && (state_ff != nat_pkg::INC_RESOLVED);

   // fold this entry into the passing token
   always_comb begin
      tok_in_c = tok_in;
      if (valid_ff && (node_ff == req.node_id) && (seq_ff == req.sequence_req) &&
          !tok_in.mhit) begin
         tok_in_c.mhit  = 1'b1;
         tok_in_c.mslot = my_idx;
      end
      if (!valid_ff && !tok_in.fhit) begin
         tok_in_c.fhit  = 1'b1;
         tok_in_c.fslot = my_idx;
      end
      if (!tok_in.ohit || (created_ff < tok_in.otime)) begin
         tok_in_c.ohit  = 1'b1;
         tok_in_c.otime = created_ff;
         tok_in_c.oslot = my_idx;
      end
      if (stat_hit) begin
         tok_in_c.ucnt = tok_in.ucnt + nat_pkg::nat_icnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_c;
         if (wr_hit && wr.create) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // entry payload: create, refresh, or status update as the token passes
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         updated_ff <= req.now_ms;
         if (wr.create) begin
            node_ff    <= req.node_id;
            seq_ff     <= req.sequence_req;
            link_ff    <= wr.link;
            state_ff   <= nat_pkg::INC_ACTIVE;
            created_ff <= req.now_ms;
         end
      end else if (stat_hit) begin
         state_ff   <= req.status_code;
         updated_ff <= req.now_ms;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

@@ hdl/node_and_incident_table.sv @@
`default_nettype none
// Node and incident table. One beat in, one beat out. Each table is a row of
// cells; a search token walks the node row one cell per cycle (lookup, first
// free slot, oldest last-seen, and the counts), then for a report the chosen
// node slot is written, then, but for a report without sos, a token walks the
// incident row (match, free, oldest created, or the status update of every
// non-resolved incident of the node), then for a report the incident slot is
// written, and the result beat is held until taken. The next request is taken
// after that.
module node_and_incident_table (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // node_id, sequence_req, hop_count, signal_strength, sos_flag, status_code,
   // now_ms, zero pad
   input  wire  [103:0] req_tdata,
   // command
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // node_slot, node_evicted, incident_action, incident_slot, node_count,
   // active_sos_count, incidents_updated, zero pad
   output logic [31:0]  rsp_tdata
);

   nat_pkg::nat_state_type    state_ff, state_in;
   nat_pkg::nat_req_type      req_ff;
   logic                      start_ff;
   logic                      istart;
   nat_pkg::nat_nwr_type      nwr;
   nat_pkg::nat_iwr_type      iwr;
   nat_pkg::nat_node_tok_type ntok [nat_pkg::NODE_SLOTS+1];
   nat_pkg::nat_inc_tok_type  itok [nat_pkg::INCIDENT_SLOTS+1];
   nat_pkg::nat_node_tok_type nend;
   nat_pkg::nat_inc_tok_type  iend;

   nat_pkg::nat_nidx_type     nslot_ff, nslot_in;
   logic                      evict_ff, evict_in;
   nat_pkg::nat_ncnt_type     vcnt_ff, vcnt_in;
   nat_pkg::nat_ncnt_type     scnt_ff, scnt_in;
   logic [1:0]                action_ff, action_in;
   nat_pkg::nat_iidx_type     islot_ff, islot_in;
   nat_pkg::nat_icnt_type     ucnt_ff;
   logic                      old_act;
   logic                      vinc;

   logic                      req_acc;
   logic                      is_report;

   assign req_acc   = req_tvalid && req_tready;
   assign is_report = (req_ff.command == nat_pkg::CMD_REPORT);
   assign nend      = ntok[nat_pkg::NODE_SLOTS];
   assign iend      = itok[nat_pkg::INCIDENT_SLOTS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nat_pkg::ST_IDLE:   if (req_tvalid) state_in = nat_pkg::ST_NSCAN;
         nat_pkg::ST_NSCAN:  if (nend.vld) state_in = nat_pkg::ST_NWRITE;
         nat_pkg::ST_NWRITE: begin
            if (is_report && !req_ff.sos_flag) state_in = nat_pkg::ST_RESP;
            else state_in = nat_pkg::ST_ISCAN;
         end
         nat_pkg::ST_ISCAN: begin
            if (iend.vld) state_in = is_report ? nat_pkg::ST_IWRITE : nat_pkg::ST_RESP;
         end
         nat_pkg::ST_IWRITE: state_in = nat_pkg::ST_RESP;
         nat_pkg::ST_RESP:   if (rsp_tready) state_in = nat_pkg::ST_IDLE;
         default:            state_in = nat_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = (state_ff == nat_pkg::ST_IDLE);
      rsp_tvalid  = (state_ff == nat_pkg::ST_RESP);
      nwr.en      = (state_ff == nat_pkg::ST_NWRITE) && is_report;
      nwr.slot    = nslot_ff;
      istart      = (state_ff == nat_pkg::ST_NWRITE) && !(is_report && !req_ff.sos_flag);
      iwr.en      = (state_ff == nat_pkg::ST_IWRITE);
      iwr.create  = (action_ff != nat_pkg::ACT_REFRESH);
      iwr.slot    = islot_ff;
      iwr.link    = 16'(nslot_ff);
   end

   // node slot choice and counts after the write
   always_comb begin
      if (nend.mhit) begin
         nslot_in = nend.mslot;
         evict_in = 1'b0;
         old_act  = nend.mact;
         vinc     = 1'b0;
      end else if (nend.fhit) begin
         nslot_in = nend.fslot;
         evict_in = 1'b0;
         old_act  = 1'b0;
         vinc     = 1'b1;
      end else begin
         nslot_in = nend.oslot;
         evict_in = 1'b1;
         old_act  = nend.oact;
         vinc     = 1'b0;
      end
      if (is_report) begin
         vcnt_in = nend.vcnt + nat_pkg::nat_ncnt_type'(vinc);
         scnt_in = nend.scnt - nat_pkg::nat_ncnt_type'(old_act)
                   + nat_pkg::nat_ncnt_type'(req_ff.sos_flag);
      end else begin
         nslot_in = '0;
         evict_in = 1'b0;
         vcnt_in  = nend.vcnt;
         scnt_in  = nend.scnt;
      end
   end

   // incident slot choice
   always_comb begin
      if (iend.mhit) begin
         action_in = nat_pkg::ACT_REFRESH;
         islot_in  = iend.mslot;
      end else if (iend.fhit) begin
         action_in = nat_pkg::ACT_CREATE_FREE;
         islot_in  = iend.fslot;
      end else begin
         action_in = nat_pkg::ACT_CREATE_EVICT;
         islot_in  = iend.oslot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nat_pkg::ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_acc;
      end
   end

   // request and result registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_ff.node_id         <= req_tdata[15:0];
         req_ff.sequence_req    <= req_tdata[47:16];
         req_ff.hop_count       <= req_tdata[55:48];
         req_ff.signal_strength <= req_tdata[63:56];
         req_ff.sos_flag        <= req_tdata[64];
         req_ff.status_code     <= req_tdata[67:65];
         req_ff.now_ms          <= req_tdata[99:68];
         req_ff.command         <= req_tuser[0];
         action_ff              <= nat_pkg::ACT_NONE;
         islot_ff               <= '0;
         ucnt_ff                <= '0;
      end
      if ((state_ff == nat_pkg::ST_NSCAN) && nend.vld) begin
         nslot_ff <= nslot_in;
         evict_ff <= evict_in;
         vcnt_ff  <= vcnt_in;
         scnt_ff  <= scnt_in;
      end
      if ((state_ff == nat_pkg::ST_ISCAN) && iend.vld) begin
         if (is_report) begin
            action_ff <= action_in;
            islot_ff  <= islot_in;
         end else begin
            ucnt_ff <= iend.ucnt;
         end
      end
   end

   // tokens entering the rows
   always_comb begin
      ntok[0]     = '0;
      ntok[0].vld = start_ff;
      itok[0]          = '0;
      itok[0].vld      = istart;
      itok[0].upd_mode = !is_report;
   end

   for (genvar i = 0; i < nat_pkg::NODE_SLOTS; i++) begin : g_node
      nat_node_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .my_idx  (nat_pkg::nat_nidx_type'(i)),
         .req     (req_ff),
         .wr      (nwr),
         .tok_in  (ntok[i]),
         .tok_out (ntok[i+1])
      );
   end

   for (genvar i = 0; i < nat_pkg::INCIDENT_SLOTS; i++) begin : g_inc
      nat_inc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .my_idx  (nat_pkg::nat_iidx_type'(i)),
         .req     (req_ff),
         .wr      (iwr),
         .tok_in  (itok[i]),
         .tok_out (itok[i+1])
      );
   end

   assign rsp_tdata = {1'b0,
                       6'(ucnt_ff),
                       6'(scnt_ff),
                       6'(vcnt_ff),
                       5'(islot_ff),
                       action_ff,
                       evict_ff,
                       5'(nslot_ff)};

   // checks
   a_noact_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (action_ff == nat_pkg::ACT_NONE) |-> (islot_ff == '0))
      else $error("incident slot set without action");
   a_status_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !is_report |-> (nslot_ff == '0) && !evict_ff &&
      (action_ff == nat_pkg::ACT_NONE))
      else $error("status result carries report fields");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(vcnt_ff) <= 32'(nat_pkg::NODE_SLOTS)) && (scnt_ff <= vcnt_ff))
      else $error("node counts out of range");
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !rsp_tvalid && !istart)
      else $error("result or incident walk right after accept");

endmodule
`default_nettype wire
